[rtl/core/naive_substring_search_assert.svh]
// ----------------------------------------------------------------------------
// naive_substring_search assertion macros
// Concurrent check helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef NAIVE_SUBSTRING_SEARCH_ASSERT_SVH
`define NAIVE_SUBSTRING_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NSS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define NSS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define NSS_ASSERT_IMP(label, clk, rst, cond, prop, msg)
`define NSS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

[rtl/core/nss_pkg.sv]
// ----------------------------------------------------------------------------
// nss_pkg
// Sizes and command codes of the substring search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

   // store capacity in bytes
   localparam int MAX_CHARS = 32;
   localparam int IDX_W     = $clog2(MAX_CHARS);
   localparam int LEN_W     = $clog2(MAX_CHARS + 1);

   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int CMP_W  = 9;
   localparam int POS_W  = 6;
   localparam int CMP_MAX = 255;
   localparam int DIFF_W = LEN_W + CMP_W;

   localparam int RSP_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_TEXT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PATTERN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;

   localparam logic KIND_COMPARE = 1'b0;
   localparam logic KIND_SEARCH  = 1'b1;

   typedef logic [LEN_W-1:0] len_type;
   typedef logic [BYTE_W-1:0] byte_type;

endpackage : nss_pkg

`default_nettype wire

[rtl/core/naive_substring_search.sv]
// ----------------------------------------------------------------------------
// naive_substring_search
// Byte-loaded text and pattern stores with lexicographic compare and
// brute-force first-occurrence search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_ (tuser = command, tdata = byte). Commands 0 and 1
//   append a byte to the text or pattern store, 2 empties both, 3 compares
//   text against pattern, 4 searches the pattern in the text. Only 3 and 4
//   return a response on rsp_; unused commands are taken and dropped.
//   Loads and clears are done in the idle state. Each compare or search step
//   reads both single-port stores and checks the bytes in the next cycle.
//   A compare ends at the first differing byte or at the end of the shorter
//   string; a search ends at the first full match, or when the pattern no
//   longer fits in the text that is left; the final state hands the result
//   to the output register.
//   One request is worked at a time; req_tready is high while no compare or
//   search is in flight. A response waiting on a stalled receiver does not
//   block loads, but the next compare or search holds in its final state
//   until the output register frees up.
//   Reset empties both stores (lengths to zero) and drops any response.
//   Store contents are not cleared; only bytes below the length are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "naive_substring_search_assert.svh"

module naive_substring_search (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [nss_pkg::BYTE_W-1:0]         req_tdata,  // [7:0] byte_value
   input  wire  [nss_pkg::CMD_W-1:0]          req_tuser,  // [2:0] command
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [8:0] compare_value, [9] found, [15:10] match_position
   output logic [nss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [0:0]                         rsp_tuser   // [0] result_kind
);

   import nss_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CFETCH = 3'd1;
   localparam logic [2:0] S_CCHECK = 3'd2;
   localparam logic [2:0] S_SFETCH = 3'd3;
   localparam logic [2:0] S_SCHECK = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // byte stores
   byte_type text_mem [MAX_CHARS];
   byte_type pat_mem  [MAX_CHARS];

   logic [2:0] state_ff, state_in;
   len_type    text_len_ff, text_len_in;
   len_type    pat_len_ff, pat_len_in;
   len_type    idx_ff, idx_in;      // compare index, or pattern offset k in search
   len_type    start_ff, start_in;  // search start position

   logic                    res_kind_ff, res_kind_in;
   logic signed [CMP_W-1:0] res_cmp_ff, res_cmp_in;
   logic                    res_found_ff, res_found_in;
   logic [POS_W-1:0]        res_pos_ff, res_pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;

   logic             req_accept;
   logic             t_wr_en, p_wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] t_rd_addr, p_rd_addr;
   byte_type         t_rd_data_ff, p_rd_data_ff;
   logic             slot_free;

   logic [LEN_W:0]           text_addr_sum;
   logic [LEN_W:0]           span_end;
   logic signed [DIFF_W-1:0] len_diff;
   logic signed [CMP_W-1:0]  len_diff_sat;
   logic signed [CMP_W-1:0]  byte_diff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // append writes land at the current length
   assign t_wr_en = req_accept && (req_tuser == CMD_TEXT) && (text_len_ff < len_type'(MAX_CHARS));
   assign p_wr_en = req_accept && (req_tuser == CMD_PATTERN) && (pat_len_ff < len_type'(MAX_CHARS));

   // search reads text at start+k, compare at i; pattern at k or i
   assign text_addr_sum = {1'b0, start_ff} + {1'b0, idx_ff};
   assign span_end      = {1'b0, start_ff} + {1'b0, pat_len_ff};
   assign t_rd_addr     = (state_ff == S_SFETCH) ? text_addr_sum[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign p_rd_addr     = idx_ff[IDX_W-1:0];

   // length difference, clamped to the result range
   assign len_diff = $signed(DIFF_W'(text_len_ff)) - $signed(DIFF_W'(pat_len_ff));
   always_comb begin
      priority if (len_diff > $signed(DIFF_W'(CMP_MAX))) begin
         len_diff_sat = CMP_W'(CMP_MAX);
      end else if (len_diff < -$signed(DIFF_W'(CMP_MAX))) begin
         len_diff_sat = -CMP_W'(CMP_MAX);
      end else begin
         len_diff_sat = len_diff[CMP_W-1:0];
      end
   end

   assign byte_diff = $signed({1'b0, t_rd_data_ff}) - $signed({1'b0, p_rd_data_ff});

   // memories: one write and one registered read per store
   always_ff @(posedge clock) begin
      if (t_wr_en) begin
         text_mem[text_len_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (rd_en) begin
         t_rd_data_ff <= text_mem[t_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (p_wr_en) begin
         pat_mem[pat_len_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (rd_en) begin
         p_rd_data_ff <= pat_mem[p_rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      text_len_in  = text_len_ff;
      pat_len_in   = pat_len_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      res_kind_in  = res_kind_ff;
      res_cmp_in   = res_cmp_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in   = '0;
               start_in = '0;
               unique case (req_tuser)
                  CMD_TEXT: begin
                     if (t_wr_en) begin
                        text_len_in = text_len_ff + len_type'(1);
                     end
                  end
                  CMD_PATTERN: begin
                     if (p_wr_en) begin
                        pat_len_in = pat_len_ff + len_type'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     text_len_in = '0;
                     pat_len_in  = '0;
                  end
                  CMD_COMPARE: begin
                     res_kind_in  = KIND_COMPARE;
                     res_found_in = 1'b0;
                     res_pos_in   = '0;
                     state_in     = S_CFETCH;
                  end
                  CMD_SEARCH: begin
                     res_kind_in  = KIND_SEARCH;
                     res_cmp_in   = '0;
                     state_in     = S_SFETCH;
                  end
                  default: begin
                     // drop unused commands
                  end
               endcase
            end
         end
         S_CFETCH: begin
            if ((idx_ff >= text_len_ff) || (idx_ff >= pat_len_ff)) begin
               res_cmp_in = len_diff_sat;
               state_in   = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CCHECK;
            end
         end
         S_CCHECK: begin
            if (t_rd_data_ff != p_rd_data_ff) begin
               res_cmp_in = byte_diff;
               state_in   = S_DONE;
            end else begin
               idx_in   = idx_ff + len_type'(1);
               state_in = S_CFETCH;
            end
         end
         S_SFETCH: begin
            priority if (idx_ff == pat_len_ff) begin
               // whole pattern matched (or pattern empty)
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(start_ff);
               state_in     = S_DONE;
            end else if (span_end > {1'b0, text_len_ff}) begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCHECK;
            end
         end
         S_SCHECK: begin
            if (t_rd_data_ff == p_rd_data_ff) begin
               idx_in = idx_ff + len_type'(1);
            end else begin
               idx_in   = '0;
               start_in = start_ff + len_type'(1);
            end
            state_in = S_SFETCH;
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = {res_pos_ff, res_found_ff, res_cmp_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         text_len_ff  <= '0;
         pat_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         text_len_ff  <= text_len_in;
         pat_len_ff   <= pat_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      start_ff     <= start_in;
      res_kind_ff  <= res_kind_in;
      res_cmp_ff   <= res_cmp_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // ---------------------------------------------------------------- checks
   `NSS_ASSERT_IMP(a_len_bound, clock, reset, 1'b1,
      (text_len_ff <= len_type'(MAX_CHARS)) && (pat_len_ff <= len_type'(MAX_CHARS)),
      "store length beyond capacity")

   `NSS_ASSERT_IMP(a_no_write_busy, clock, reset, state_ff != S_IDLE,
      !t_wr_en && !p_wr_en, "store written during compare or search")

   `NSS_ASSERT_IMP(a_cmp_index, clock, reset, state_ff == S_CCHECK,
      (idx_ff < text_len_ff) && (idx_ff < pat_len_ff), "compare read beyond a length")

   `NSS_ASSERT_IMP(a_match_fits, clock, reset,
      (state_ff == S_DONE) && (res_kind_ff == KIND_SEARCH) && res_found_ff,
      (span_end <= {1'b0, text_len_ff}), "match extends past the text")

   `NSS_ASSERT_NEXT(a_done_hold, clock, reset,
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_tready,
      (state_ff == S_DONE) && rsp_valid_ff, "result lost while receiver stalled")

endmodule : naive_substring_search

`default_nettype wire
